// ===== rtl/pis_pkg.sv =====
// ----------------------------------------------------------------------------
// pis_pkg
// shared types and constants of the point-in-spheroid test pipeline
// ----------------------------------------------------------------------------
package pis_pkg;

    // width of one operand slice in the split multipliers
    localparam int CHUNK_W = 32;

    // control that travels with an item down the pipeline
    typedef struct packed {
        logic valid;
        logic deg;
    } pis_ctl_t;

endpackage

// ===== rtl/pis_wmul.sv =====
// ----------------------------------------------------------------------------
// pis_wmul
// two-stage unsigned multiplier, operands cut into slices of at most 32 bits;
// slice products registered first, then summed
// ----------------------------------------------------------------------------
module pis_wmul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int CW = pis_pkg::CHUNK_W;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int SW = (NA + NB) * CW;

    logic [NA*CW-1:0]   a_ext;
    logic [NB*CW-1:0]   b_ext;
    logic [2*CW-1:0]    pp_reg [NA][NB];
    logic [SW-1:0]      sum_next;
    logic [AW+BW-1:0]   p_reg;

    assign a_ext = (NA*CW)'(a);
    assign b_ext = (NB*CW)'(b);

    // slice products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
            end
        end
    end

    // weighted sum of slice products
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + (SW'(pp_reg[i][j]) << (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= sum_next[AW+BW-1:0];
    end

    assign p = p_reg;

endmodule

// ===== rtl/pis_front.sv =====
// ----------------------------------------------------------------------------
// pis_front
// first three stages: offset from center and squared semi-axes, coordinate
// products, then projection on the axis, cross product magnitudes and |m|^2
// ----------------------------------------------------------------------------
module pis_front #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] axis_x,
    input  logic signed [W-1:0] axis_y,
    input  logic signed [W-1:0] axis_z,
    input  logic signed [W-1:0] center_x,
    input  logic signed [W-1:0] center_y,
    input  logic signed [W-1:0] center_z,
    input  logic [W-2:0]        semi_main,
    input  logic [W-2:0]        semi_side,
    input  logic signed [W-1:0] point_x,
    input  logic signed [W-1:0] point_y,
    input  logic signed [W-1:0] point_z,
    output logic [2*W:0]        t_abs,
    output logic [2*W-1:0]      cx_abs,
    output logic [2*W-1:0]      cy_abs,
    output logic [2*W-1:0]      cz_abs,
    output logic [2*W-1:0]      mm,
    output logic [2*W-3:0]      aa,
    output logic [2*W-3:0]      bb,
    output pis_pkg::pis_ctl_t   ctl
);

    localparam int PW  = 2 * W + 1;   // signed coordinate product
    localparam int TSW = 2 * W + 2;   // signed projection sum
    localparam int CSW = 2 * W + 1;   // signed cross component

    // stage 1
    logic signed [W:0]   d_reg  [3];
    logic signed [W:0]   d_next [3];
    logic signed [W-1:0] m_reg  [3];
    logic [2*W-3:0]      aa1_reg;
    logic [2*W-3:0]      bb1_reg;
    pis_pkg::pis_ctl_t   ctl1_reg;
    pis_pkg::pis_ctl_t   ctl1_next;

    // stage 2
    logic signed [PW-1:0] p_reg [3][3];
    logic [2*W-2:0]       msq_reg [3];
    logic [2*W-3:0]       aa2_reg;
    logic [2*W-3:0]       bb2_reg;
    pis_pkg::pis_ctl_t    ctl2_reg;

    // stage 3
    logic signed [TSW-1:0] t_sum;
    logic signed [TSW-1:0] t_neg;
    logic signed [CSW-1:0] c_sum [3];
    logic signed [CSW-1:0] c_neg [3];
    logic [2*W:0]          t_abs_reg;
    logic [2*W-1:0]        c_abs_reg [3];
    logic [2*W-1:0]        mm_reg;
    logic [2*W-1:0]        mm_next;
    logic [2*W-3:0]        aa3_reg;
    logic [2*W-3:0]        bb3_reg;
    pis_pkg::pis_ctl_t     ctl3_reg;

    always_comb
    begin
        d_next[0] = $signed({point_x[W-1], point_x}) - $signed({center_x[W-1], center_x});
        d_next[1] = $signed({point_y[W-1], point_y}) - $signed({center_y[W-1], center_y});
        d_next[2] = $signed({point_z[W-1], point_z}) - $signed({center_z[W-1], center_z});
        ctl1_next.valid = start;
        ctl1_next.deg   = ((axis_x == '0) && (axis_y == '0) && (axis_z == '0)) ||
                          (semi_main == '0) || (semi_side == '0);
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= d_next[i];
        end
        m_reg[0] <= axis_x;
        m_reg[1] <= axis_y;
        m_reg[2] <= axis_z;
        aa1_reg  <= (2*W-2)'(semi_main) * (2*W-2)'(semi_main);
        bb1_reg  <= (2*W-2)'(semi_side) * (2*W-2)'(semi_side);
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_reg[i][j] <= PW'(d_reg[i]) * PW'(m_reg[j]);
            end
            msq_reg[i] <= (2*W-1)'(m_reg[i]) * (2*W-1)'(m_reg[i]);
        end
        aa2_reg <= aa1_reg;
        bb2_reg <= bb1_reg;
    end

    // projection on axis and cross product
    always_comb
    begin
        t_sum    = TSW'(p_reg[0][0]) + TSW'(p_reg[1][1]) + TSW'(p_reg[2][2]);
        t_neg    = -t_sum;
        c_sum[0] = CSW'(p_reg[1][2]) - CSW'(p_reg[2][1]);
        c_sum[1] = CSW'(p_reg[2][0]) - CSW'(p_reg[0][2]);
        c_sum[2] = CSW'(p_reg[0][1]) - CSW'(p_reg[1][0]);
        for (int i = 0; i < 3; i++)
        begin
            c_neg[i] = -c_sum[i];
        end
        mm_next  = (2*W)'(msq_reg[0]) + (2*W)'(msq_reg[1]) + (2*W)'(msq_reg[2]);
    end

    // stage 3 payload
    always_ff @(posedge clk)
    begin
        t_abs_reg <= t_sum[TSW-1] ? t_neg[2*W:0] : t_sum[2*W:0];
        for (int i = 0; i < 3; i++)
        begin
            c_abs_reg[i] <= c_sum[i][CSW-1] ? c_neg[i][2*W-1:0] : c_sum[i][2*W-1:0];
        end
        mm_reg  <= mm_next;
        aa3_reg <= aa2_reg;
        bb3_reg <= bb2_reg;
    end

    // control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    assign t_abs  = t_abs_reg;
    assign cx_abs = c_abs_reg[0];
    assign cy_abs = c_abs_reg[1];
    assign cz_abs = c_abs_reg[2];
    assign mm     = mm_reg;
    assign aa     = aa3_reg;
    assign bb     = bb3_reg;
    assign ctl    = ctl3_reg;

endmodule

// ===== rtl/point_in_spheroid_test_top.sv =====
// Each item is taken whenever start is high: busy is always low and one item
// can enter in every clock cycle. The result of an item is on the outputs,
// marked by a one-cycle done pulse, in the order the items came in; the
// receiver cannot hold it off and must take it in that cycle. Ten register
// stages lie between input and result: offset from the center, coordinate
// products, projection and cross product, squares (two stages), the sum of
// the cross terms, products with the squared semi-axes (two stages), the sum
// of the left side and the final compare.
// ----------------------------------------------------------------------------
// point_in_spheroid_test_top
// pipelined test of a point against a spheroid given by axis, center and
// semi-axes, evaluated exactly in integer arithmetic
// ----------------------------------------------------------------------------
module point_in_spheroid_test_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] axis_x,
    input  logic signed [COORD_WIDTH-1:0] axis_y,
    input  logic signed [COORD_WIDTH-1:0] axis_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        semi_main,
    input  logic [COORD_WIDTH-2:0]        semi_side,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          done,
    output logic                          inside_res,
    output logic                          degenerate
);

    localparam int W    = COORD_WIDTH;
    localparam int TW   = 2 * W + 1;   // |t|
    localparam int CW   = 2 * W;       // |cross component|, |m|^2
    localparam int SQW  = 2 * W - 2;   // a^2, b^2
    localparam int T2W  = 2 * TW;      // t^2
    localparam int C2W  = 2 * CW;      // cross component squared
    localparam int X2W  = 4 * W + 2;   // |d x m|^2
    localparam int ABW  = 2 * SQW;     // a^2 b^2
    localparam int RW   = ABW + CW;    // right side
    localparam int L1W  = T2W + SQW;
    localparam int L2W  = X2W + SQW;
    localparam int LW   = 6 * W + 1;   // left side
    localparam int NCTL = 6;           // control stages 4 to 9

    logic [TW-1:0]  t_abs;
    logic [CW-1:0]  cx_abs;
    logic [CW-1:0]  cy_abs;
    logic [CW-1:0]  cz_abs;
    logic [CW-1:0]  mm;
    logic [SQW-1:0] aa;
    logic [SQW-1:0] bb;
    pis_pkg::pis_ctl_t ctl3;

    logic [T2W-1:0] t2;
    logic [C2W-1:0] cx2;
    logic [C2W-1:0] cy2;
    logic [C2W-1:0] cz2;
    logic [ABW-1:0] ab;
    logic [RW-1:0]  rhs;
    logic [L1W-1:0] l1;
    logic [L2W-1:0] l2;

    pis_pkg::pis_ctl_t ctl_reg [NCTL];
    logic [SQW-1:0]    aa_d_reg [3];
    logic [SQW-1:0]    bb_d_reg [3];
    logic [CW-1:0]     mm_d_reg [2];
    logic [RW-1:0]     rhs_d_reg [2];
    logic [T2W-1:0]    t2_reg;
    logic [X2W-1:0]    cross2_reg;
    logic [X2W-1:0]    cross2_next;
    logic [LW-1:0]     lhs_reg;
    logic [LW-1:0]     lhs_next;
    logic              done_reg;
    logic              inside_reg;
    logic              inside_next;
    logic              degenerate_reg;

    pis_front #(
        .W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .center_x  (center_x),
        .center_y  (center_y),
        .center_z  (center_z),
        .semi_main (semi_main),
        .semi_side (semi_side),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .t_abs     (t_abs),
        .cx_abs    (cx_abs),
        .cy_abs    (cy_abs),
        .cz_abs    (cz_abs),
        .mm        (mm),
        .aa        (aa),
        .bb        (bb),
        .ctl       (ctl3)
    );

    // squares and a^2 b^2, stages 4 and 5
    pis_wmul #(.AW(TW),  .BW(TW))  u_t2  (.clk(clk), .a(t_abs),  .b(t_abs),  .p(t2));
    pis_wmul #(.AW(CW),  .BW(CW))  u_cx2 (.clk(clk), .a(cx_abs), .b(cx_abs), .p(cx2));
    pis_wmul #(.AW(CW),  .BW(CW))  u_cy2 (.clk(clk), .a(cy_abs), .b(cy_abs), .p(cy2));
    pis_wmul #(.AW(CW),  .BW(CW))  u_cz2 (.clk(clk), .a(cz_abs), .b(cz_abs), .p(cz2));
    pis_wmul #(.AW(SQW), .BW(SQW)) u_ab  (.clk(clk), .a(aa),     .b(bb),     .p(ab));

    // right side, stages 6 and 7
    pis_wmul #(.AW(ABW), .BW(CW)) u_rhs (
        .clk (clk),
        .a   (ab),
        .b   (mm_d_reg[1]),
        .p   (rhs)
    );

    // left side terms, stages 7 and 8
    pis_wmul #(.AW(T2W), .BW(SQW)) u_l1 (
        .clk (clk),
        .a   (t2_reg),
        .b   (bb_d_reg[2]),
        .p   (l1)
    );

    pis_wmul #(.AW(X2W), .BW(SQW)) u_l2 (
        .clk (clk),
        .a   (cross2_reg),
        .b   (aa_d_reg[2]),
        .p   (l2)
    );

    always_comb
    begin
        cross2_next = X2W'(cx2) + X2W'(cy2) + X2W'(cz2);
        lhs_next    = LW'(l1) + LW'(l2);
        inside_next = !ctl_reg[NCTL-1].deg && (lhs_reg <= LW'(rhs_d_reg[1]));
    end

    // payload line
    always_ff @(posedge clk)
    begin
        aa_d_reg[0]  <= aa;
        aa_d_reg[1]  <= aa_d_reg[0];
        aa_d_reg[2]  <= aa_d_reg[1];
        bb_d_reg[0]  <= bb;
        bb_d_reg[1]  <= bb_d_reg[0];
        bb_d_reg[2]  <= bb_d_reg[1];
        mm_d_reg[0]  <= mm;
        mm_d_reg[1]  <= mm_d_reg[0];
        t2_reg       <= t2;
        cross2_reg   <= cross2_next;
        rhs_d_reg[0] <= rhs;
        rhs_d_reg[1] <= rhs_d_reg[0];
        lhs_reg      <= lhs_next;
        inside_reg   <= inside_next;
        degenerate_reg <= ctl_reg[NCTL-1].deg;
    end

    // control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCTL; i++)
            begin
                ctl_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg[0] <= ctl3;
            for (int i = 1; i < NCTL; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            done_reg <= ctl_reg[NCTL-1].valid;
        end
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign degenerate = degenerate_reg;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pipelined point-in-spheroid test; items go in
// through the start/busy handshake under three idle patterns, each accepted
// item is classified by exact 128-bit integer math and every done pulse is
// compared in order against that verdict
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW         = 16;
    localparam int CLK_PERIOD = 12;
    localparam int PHASE_LEN  = 175;

    typedef struct {
        logic signed [CW-1:0] axis_x;
        logic signed [CW-1:0] axis_y;
        logic signed [CW-1:0] axis_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic [CW-2:0]        semi_main;
        logic [CW-2:0]        semi_side;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } spheroid_item_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } verdict_t;

    class spheroid_checker;
        verdict_t expected_verdicts[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function verdict_t classify_point(spheroid_item_t it);
            logic signed [127:0] dx, dy, dz, mx, my, mz, aa, bb;
            logic signed [127:0] proj, crx, cry, crz, cross2, mm, lhs, rhs;
            verdict_t v;
            mx = it.axis_x;
            my = it.axis_y;
            mz = it.axis_z;
            dx = it.point_x - it.center_x;
            dy = it.point_y - it.center_y;
            dz = it.point_z - it.center_z;
            aa = it.semi_main;
            bb = it.semi_side;
            aa = aa * aa;
            bb = bb * bb;
            if ((mx == 0 && my == 0 && mz == 0) || aa == 0 || bb == 0)
            begin
                v.inside_res = 1'b0;
                v.degenerate = 1'b1;
                return v;
            end
            proj   = dx * mx + dy * my + dz * mz;
            crx    = dy * mz - dz * my;
            cry    = dz * mx - dx * mz;
            crz    = dx * my - dy * mx;
            cross2 = crx * crx + cry * cry + crz * crz;
            mm     = mx * mx + my * my + mz * mz;
            lhs    = proj * proj * bb + cross2 * aa;
            rhs    = aa * bb * mm;
            v.inside_res = (lhs <= rhs);
            v.degenerate = 1'b0;
            return v;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_item(spheroid_item_t it);
            expected_verdicts.push_back(classify_point(it));
        endfunction

        task check_result(logic inside_res, logic degenerate);
            verdict_t exp_v;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("unexpected result inside_res=%b degenerate=%b",
                                 inside_res, degenerate));
                return;
            end
            exp_v = expected_verdicts.pop_front();
            if (inside_res !== exp_v.inside_res)
                report($sformatf("inside_res %b, expected %b", inside_res, exp_v.inside_res));
            if (degenerate !== exp_v.degenerate)
                report($sformatf("degenerate %b, expected %b", degenerate, exp_v.degenerate));
        endtask

        task check_drained();
            if (expected_verdicts.size() != 0)
                report($sformatf("%0d results never arrived", expected_verdicts.size()));
        endtask
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic signed [CW-1:0] axis_x     = '0;
    logic signed [CW-1:0] axis_y     = '0;
    logic signed [CW-1:0] axis_z     = '0;
    logic signed [CW-1:0] center_x   = '0;
    logic signed [CW-1:0] center_y   = '0;
    logic signed [CW-1:0] center_z   = '0;
    logic [CW-2:0]        semi_main  = '0;
    logic [CW-2:0]        semi_side  = '0;
    logic signed [CW-1:0] point_x    = '0;
    logic signed [CW-1:0] point_y    = '0;
    logic signed [CW-1:0] point_z    = '0;
    logic                 busy;
    logic                 done;
    logic                 inside_res;
    logic                 degenerate;

    spheroid_checker sb = new();

    point_in_spheroid_test_top #(
        .COORD_WIDTH(CW)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .semi_main  (semi_main),
        .semi_side  (semi_side),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .done       (done),
        .inside_res (inside_res),
        .degenerate (degenerate)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // results are checked before the item taken at the same edge is noted
    always @(posedge clk)
    begin
        spheroid_item_t seen;
        if (rst_n)
        begin
            if (done)
                sb.check_result(inside_res, degenerate);
            if (start && !busy)
            begin
                seen.axis_x    = axis_x;
                seen.axis_y    = axis_y;
                seen.axis_z    = axis_z;
                seen.center_x  = center_x;
                seen.center_y  = center_y;
                seen.center_z  = center_z;
                seen.semi_main = semi_main;
                seen.semi_side = semi_side;
                seen.point_x   = point_x;
                seen.point_y   = point_y;
                seen.point_z   = point_z;
                sb.note_item(seen);
            end
        end
    end

    function automatic spheroid_item_t make_item(int ax, int ay, int az,
                                                 int cx, int cy, int cz,
                                                 int a, int b,
                                                 int px, int py, int pz);
        spheroid_item_t it;
        it.axis_x    = CW'(ax);
        it.axis_y    = CW'(ay);
        it.axis_z    = CW'(az);
        it.center_x  = CW'(cx);
        it.center_y  = CW'(cy);
        it.center_z  = CW'(cz);
        it.semi_main = (CW-1)'(a);
        it.semi_side = (CW-1)'(b);
        it.point_x   = CW'(px);
        it.point_y   = CW'(py);
        it.point_z   = CW'(pz);
        return it;
    endfunction

    function automatic int signed_range(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic spheroid_item_t random_item();
        int m[3];
        int c[3];
        int off[3];
        int sel;
        int k;
        int a;
        int b;
        sel = $urandom_range(99);
        for (int i = 0; i < 3; i++)
        begin
            m[i]   = full_coord();
            c[i]   = full_coord();
            off[i] = full_coord();
        end
        a = $urandom_range(32767);
        b = $urandom_range(32767);
        if (sel < 30)
        begin
            // fully random, offset used as the point itself
            return make_item(m[0], m[1], m[2], c[0], c[1], c[2], a, b,
                             off[0], off[1], off[2]);
        end
        if (sel < 55)
        begin
            // small world, both verdicts common
            for (int i = 0; i < 3; i++)
            begin
                m[i]   = signed_range(64);
                c[i]   = signed_range(20000);
                off[i] = signed_range(64);
            end
            a = $urandom_range(1, 64);
            b = $urandom_range(1, 64);
        end
        else if (sel < 80)
        begin
            // point exactly on, or one step off, an axis-aligned pole or rim
            k = $urandom_range(2);
            for (int i = 0; i < 3; i++)
            begin
                m[i]   = 0;
                c[i]   = signed_range(20000);
                off[i] = 0;
            end
            m[k] = $urandom_range(1, 300) * ($urandom_range(1) ? 1 : -1);
            a = $urandom_range(1, 2000);
            b = $urandom_range(1, 2000);
            if ($urandom_range(1))
                off[k] = $urandom_range(1) ? a : -a;
            else
                off[(k + 1) % 3] = $urandom_range(1) ? b : -b;
            if ($urandom_range(2) == 0)
                off[$urandom_range(2)] += $urandom_range(1) ? 1 : -1;
        end
        else if (sel < 92)
        begin
            // large semi-axes, point near the center
            for (int i = 0; i < 3; i++)
            begin
                c[i]   = signed_range(20000);
                off[i] = signed_range(10000);
            end
            a = $urandom_range(16384, 32767);
            b = $urandom_range(16384, 32767);
        end
        else
        begin
            // degenerate shapes with random remainder
            for (int i = 0; i < 3; i++)
                off[i] = full_coord();
            case ($urandom_range(2))
                0:
                begin
                    m[0] = 0;
                    m[1] = 0;
                    m[2] = 0;
                end
                1: a = 0;
                default: b = 0;
            endcase
            return make_item(m[0], m[1], m[2], c[0], c[1], c[2], a, b,
                             off[0], off[1], off[2]);
        end
        return make_item(m[0], m[1], m[2], c[0], c[1], c[2], a, b,
                         c[0] + off[0], c[1] + off[1], c[2] + off[2]);
    endfunction

    task automatic send_item(input spheroid_item_t it, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        axis_x    <= it.axis_x;
        axis_y    <= it.axis_y;
        axis_z    <= it.axis_z;
        center_x  <= it.center_x;
        center_y  <= it.center_y;
        center_z  <= it.center_z;
        semi_main <= it.semi_main;
        semi_side <= it.semi_side;
        point_x   <= it.point_x;
        point_y   <= it.point_y;
        point_z   <= it.point_z;
        do @(posedge clk); while (busy);
    endtask

    task automatic run_directed();
        // degenerate: zero axis, zero semi-axes
        send_item(make_item(0, 0, 0, 0, 0, 0, 5, 3, 0, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0), 0);
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        // surface points count as inside, one step beyond is outside
        send_item(make_item(1, 0, 0, 0, 0, 0, 5, 3, 5, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0, 5, 3, 6, 0, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0, 5, 3, 0, 3, 0), 0);
        send_item(make_item(1, 0, 0, 0, 0, 0, 5, 3, 0, 4, 0), 0);
        send_item(make_item(-2, 0, 0, 10, 10, 10, 5, 3, 10, 10, 7), 0);
        send_item(make_item(0, 0, 1, 0, 0, 0, 1, 5, 3, 4, 0), 0);
        send_item(make_item(0, 0, 7, 0, 0, 0, 1, 5, 3, 4, 1), 0);
        send_item(make_item(3, 4, 0, 100, -100, 0, 10, 2, 106, -92, 0), 0);
        send_item(make_item(3, 4, 0, 100, -100, 0, 10, 2, 106, -92, 1), 0);
        // point at the center
        send_item(make_item(-32768, -32768, -32768, 1, 2, 3, 1, 1, 1, 2, 3), 0);
        // field extremes
        send_item(make_item(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, -32768, -32768, -32768), 0);
        send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767, 32767), 0);
        send_item(make_item(-32768, 32767, -32768, 32767, -32768, 32767,
                            32767, 1, -32768, 32767, -32768), 0);
        send_item(make_item(1, 0, 0, -32768, 0, 0, 32767, 1, -1, 0, 0), 0);
        send_item(make_item(1, 0, 0, -32768, 0, 0, 32767, 1, 0, 0, 0), 0);
        send_item(make_item(0, 1, 0, 0, 0, 0, 1, 32767, 32767, 0, 0), 0);
        send_item(make_item(-1, -1, -1, -1, -1, -1, 16384, 21845,
                            -1, -1, -1), 0);
    endtask

    initial
    begin
        int guard;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < PHASE_LEN; n++)
            send_item(random_item(), 32);
        for (int n = 0; n < PHASE_LEN; n++)
            send_item(random_item(), 62);
        for (int n = 0; n < PHASE_LEN; n++)
            send_item(random_item(), 0);
        start <= 1'b0;
        guard = 0;
        while (sb.expected_verdicts.size() != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
